>>> hdl/qslerp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and the arctangent table of the quaternion slerp pipeline.
package qslerp_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int BLEND_BITS = 18;
   localparam int THRESH_BITS = 31;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 31'd1073634450;
   localparam int FRAC_BITS = 30;
   localparam int DOT_BITS = 34;
   localparam int MAG_BITS = 31;
   localparam int RAD_BITS = 61;
   localparam int XY_BITS = 34;
   localparam int ANG_BITS = 20;
   localparam int FAC_BITS = 32;
   localparam int ONE_Q16 = 65536;
   localparam int DIV_STAGES = MAG_BITS;
   localparam logic signed [XY_BITS-1:0] INV_GAIN_Q30 = 34'sd652032874;

   typedef logic [1:0] path_type;
   localparam path_type PATH_BLEND = 2'd0;
   localparam path_type PATH_LOW = 2'd1;
   localparam path_type PATH_HIGH = 2'd2;
   localparam path_type PATH_PARALLEL = 2'd3;

   function automatic logic signed [ANG_BITS-1:0] atan_q16(input int idx);
      case (idx)
         0: return 20'sd51472;
         1: return 20'sd30385;
         2: return 20'sd16055;
         3: return 20'sd8150;
         4: return 20'sd4091;
         5: return 20'sd2047;
         6: return 20'sd1024;
         7: return 20'sd512;
         8: return 20'sd256;
         9: return 20'sd128;
         10: return 20'sd64;
         11: return 20'sd32;
         12: return 20'sd16;
         13: return 20'sd8;
         14: return 20'sd4;
         15: return 20'sd2;
         16: return 20'sd1;
         default: return 20'sd0;
      endcase
   endfunction

endpackage

>>> hdl/qslerp_req_if.sv
`timescale 1ns / 1ps
// Request channel: two quaternions and a blend factor.
interface qslerp_req_if #(
   parameter int COMPONENT_BITS = qslerp_pkg::COMPONENT_BITS_DEF
);
   logic valid;
   logic ready;
   logic signed [COMPONENT_BITS-1:0] first_w;
   logic signed [COMPONENT_BITS-1:0] first_x;
   logic signed [COMPONENT_BITS-1:0] first_y;
   logic signed [COMPONENT_BITS-1:0] first_z;
   logic signed [COMPONENT_BITS-1:0] second_w;
   logic signed [COMPONENT_BITS-1:0] second_x;
   logic signed [COMPONENT_BITS-1:0] second_y;
   logic signed [COMPONENT_BITS-1:0] second_z;
   logic signed [qslerp_pkg::BLEND_BITS-1:0] blend_factor;

   modport source (
      output valid, first_w, first_x, first_y, first_z,
      output second_w, second_x, second_y, second_z, blend_factor,
      input ready
   );
   modport sink (
      input valid, first_w, first_x, first_y, first_z,
      input second_w, second_x, second_y, second_z, blend_factor,
      output ready
   );
endinterface

>>> hdl/qslerp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: interpolated quaternion and path code.
interface qslerp_rsp_if #(
   parameter int COMPONENT_BITS = qslerp_pkg::COMPONENT_BITS_DEF
);
   logic valid;
   logic ready;
   logic signed [COMPONENT_BITS-1:0] out_w;
   logic signed [COMPONENT_BITS-1:0] out_x;
   logic signed [COMPONENT_BITS-1:0] out_y;
   logic signed [COMPONENT_BITS-1:0] out_z;
   qslerp_pkg::path_type path_code;

   modport source (output valid, out_w, out_x, out_y, out_z, path_code, input ready);
   modport sink (input valid, out_w, out_x, out_y, out_z, path_code, output ready);
endinterface

>>> hdl/qslerp_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module qslerp_isqrt #(
   parameter type SIDE_TYPE = logic
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic [qslerp_pkg::RAD_BITS-1:0]   rad,
   input  SIDE_TYPE                          enter_side,
   output logic [qslerp_pkg::MAG_BITS-1:0]   root,
   output SIDE_TYPE                          exit_side
);
   localparam int STAGES = qslerp_pkg::MAG_BITS;
   localparam int RW = qslerp_pkg::RAD_BITS;
   localparam int TW = 2 * STAGES + 1;

   logic [RW-1:0]     rem_ff  [STAGES];
   logic [STAGES-1:0] res_ff  [STAGES];
   SIDE_TYPE          side_ff [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int B = STAGES - 1 - j;
      logic [RW-1:0]     rem_src;
      logic [RW-1:0]     rem_in;
      logic [STAGES-1:0] res_src;
      logic [STAGES-1:0] res_in;
      logic [TW-1:0]     trial;
      SIDE_TYPE          side_src;

      if (j == 0) begin : g_first
         assign rem_src = rad;
         assign res_src = '0;
         assign side_src = enter_side;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign res_src = res_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_comb begin
         trial = (TW'(res_src) << (B + 1)) + (TW'(1) << (2 * B));
         rem_in = rem_src;
         res_in = res_src;
         if (TW'(rem_src) >= trial) begin
            rem_in = rem_src - trial[RW-1:0];
            res_in = res_src | (STAGES'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in;
            res_ff[j] <= res_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j] <= '0;
         end else if (enable) begin
            side_ff[j] <= side_src;
         end
      end
   end

   assign root = res_ff[STAGES-1];
   assign exit_side = side_ff[STAGES-1];
endmodule

>>> hdl/qslerp_atan.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC giving the angle of (x, y) in Q2.16 radians.
module qslerp_atan #(
   parameter int STAGES = qslerp_pkg::CORDIC_STAGES_DEF,
   parameter type SIDE_TYPE = logic
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic [qslerp_pkg::MAG_BITS-1:0]     x_start,
   input  logic [qslerp_pkg::MAG_BITS-1:0]     y_start,
   input  SIDE_TYPE                            enter_side,
   output logic signed [qslerp_pkg::ANG_BITS-1:0] theta,
   output SIDE_TYPE                            exit_side
);
   localparam int XW = qslerp_pkg::XY_BITS;
   localparam int AW = qslerp_pkg::ANG_BITS;

   logic signed [XW-1:0] x_ff [STAGES];
   logic signed [XW-1:0] y_ff [STAGES];
   logic signed [AW-1:0] z_ff [STAGES];
   SIDE_TYPE             side_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [XW-1:0] x_src, y_src, x_in, y_in;
      logic signed [AW-1:0] z_src, z_in;
      logic                 turn_down;
      SIDE_TYPE             side_src;

      if (i == 0) begin : g_first
         assign x_src = $signed(XW'(x_start));
         assign y_src = $signed(XW'(y_start));
         assign z_src = '0;
         assign side_src = enter_side;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      always_comb begin
         turn_down = !y_src[XW-1] && (y_src != '0);
         if (turn_down) begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + qslerp_pkg::atan_q16(i);
         end else begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - qslerp_pkg::atan_q16(i);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (enable) begin
            side_ff[i] <= side_src;
         end
      end
   end

   assign theta = z_ff[STAGES-1];
   assign exit_side = side_ff[STAGES-1];
endmodule

>>> hdl/qslerp_sin.sv
`timescale 1ns / 1ps
// Two-lane pipelined rotation CORDIC giving sines in Q2.30.
module qslerp_sin #(
   parameter int STAGES = qslerp_pkg::CORDIC_STAGES_DEF,
   parameter type SIDE_TYPE = logic
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic signed [qslerp_pkg::ANG_BITS-1:0] angle [2],
   input  SIDE_TYPE                               enter_side,
   output logic signed [qslerp_pkg::XY_BITS-1:0]  sine [2],
   output SIDE_TYPE                               exit_side
);
   localparam int XW = qslerp_pkg::XY_BITS;
   localparam int AW = qslerp_pkg::ANG_BITS;

   logic signed [XW-1:0] x_ff [2][STAGES];
   logic signed [XW-1:0] y_ff [2][STAGES];
   logic signed [AW-1:0] z_ff [2][STAGES];
   SIDE_TYPE             side_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      SIDE_TYPE side_src;

      if (i == 0) begin : g_side_first
         assign side_src = enter_side;
      end else begin : g_side_next
         assign side_src = side_ff[i-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [XW-1:0] x_src, y_src, x_in, y_in;
         logic signed [AW-1:0] z_src, z_in;

         if (i == 0) begin : g_first
            assign x_src = qslerp_pkg::INV_GAIN_Q30;
            assign y_src = '0;
            assign z_src = angle[l];
         end else begin : g_next
            assign x_src = x_ff[l][i-1];
            assign y_src = y_ff[l][i-1];
            assign z_src = z_ff[l][i-1];
         end

         always_comb begin
            if (!z_src[AW-1]) begin
               x_in = x_src - (y_src >>> i);
               y_in = y_src + (x_src >>> i);
               z_in = z_src - qslerp_pkg::atan_q16(i);
            end else begin
               x_in = x_src + (y_src >>> i);
               y_in = y_src - (x_src >>> i);
               z_in = z_src + qslerp_pkg::atan_q16(i);
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               x_ff[l][i] <= x_in;
               y_ff[l][i] <= y_in;
               z_ff[l][i] <= z_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (enable) begin
            side_ff[i] <= side_src;
         end
      end
   end

   assign sine[0] = y_ff[0][STAGES-1];
   assign sine[1] = y_ff[1][STAGES-1];
   assign exit_side = side_ff[STAGES-1];
endmodule

>>> hdl/qslerp_div.sv
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider forming clamped Q2.30 ratios.
module qslerp_div #(
   parameter type SIDE_TYPE = logic
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic signed [qslerp_pkg::XY_BITS-1:0]  num [2],
   input  logic [qslerp_pkg::MAG_BITS-1:0]        den,
   input  SIDE_TYPE                               enter_side,
   output logic signed [qslerp_pkg::FAC_BITS-1:0] quot [2],
   output SIDE_TYPE                               exit_side
);
   localparam int STAGES = qslerp_pkg::DIV_STAGES;
   localparam int XW = qslerp_pkg::XY_BITS;
   localparam int QW = qslerp_pkg::MAG_BITS;
   localparam int FW = qslerp_pkg::FAC_BITS;
   localparam int FB = qslerp_pkg::FRAC_BITS;
   localparam int NW = XW + FB;

   logic [NW-1:0] rem_ff  [2][STAGES+1];
   logic [QW-1:0] q_ff    [2][STAGES+1];
   logic          neg_ff  [2][STAGES+1];
   logic          ovf_ff  [2][STAGES+1];
   logic [QW-1:0] den_ff  [STAGES+1];
   SIDE_TYPE      side_ff [STAGES+1];

   for (genvar l = 0; l < 2; l++) begin : g_entry
      logic [XW-1:0] mag;
      logic          ovf_in;
      logic [NW-1:0] rem_in;

      always_comb begin
         mag = num[l][XW-1] ? XW'(-num[l]) : XW'(num[l]);
         ovf_in = mag >= XW'({den, 1'b0});
         rem_in = NW'(mag) << FB;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[l][0] <= rem_in;
            q_ff[l][0] <= '0;
            neg_ff[l][0] <= num[l][XW-1];
            ovf_ff[l][0] <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0] <= den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else if (enable) begin
         side_ff[0] <= enter_side;
      end
   end

   for (genvar j = 1; j <= STAGES; j++) begin : g_stage
      localparam int B = STAGES - j;

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [NW-1:0] dsh, rem_in;
         logic [QW-1:0] q_in;

         always_comb begin
            dsh = NW'(den_ff[j-1]) << B;
            rem_in = rem_ff[l][j-1];
            q_in = q_ff[l][j-1];
            if (rem_ff[l][j-1] >= dsh) begin
               rem_in = rem_ff[l][j-1] - dsh;
               q_in = q_ff[l][j-1] | (QW'(1) << B);
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[l][j] <= rem_in;
               q_ff[l][j] <= q_in;
               neg_ff[l][j] <= neg_ff[l][j-1];
               ovf_ff[l][j] <= ovf_ff[l][j-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[j] <= den_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j] <= '0;
         end else if (enable) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_out
      logic [QW-1:0] qsel;

      always_comb begin
         qsel = ovf_ff[l][STAGES] ? '1 : q_ff[l][STAGES];
         quot[l] = neg_ff[l][STAGES] ? -$signed(FW'(qsel)) : $signed(FW'(qsel));
      end
   end

   assign exit_side = side_ff[STAGES];
endmodule

>>> hdl/quaternion_slerp.sv
`timescale 1ns / 1ps
// Quaternion spherical interpolation pipeline, top level.
//
//   channel  dir  handshake        carries
//   req_ch   in   valid / ready    first_*, second_*, blend_factor
//   rsp_ch   out  valid / ready    out_*, path_code
//   csr_*    in   write enable     parallel_threshold (Q2.30)
//
// One request enters per cycle while the pipeline is not stalled; the path runs
// through the 31-stage root, the two CORDIC chains and the 32-stage divider.
// Reset is synchronous and clears all valid bits and restores the threshold.
// A held response stalls the pipeline only when the stage behind the output
// register is occupied; bubbles are squeezed out.
module quaternion_slerp #(
   parameter int COMPONENT_BITS = qslerp_pkg::COMPONENT_BITS_DEF,
   parameter int CORDIC_STAGES = qslerp_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   qslerp_req_if.sink                           req_ch,
   qslerp_rsp_if.source                         rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [qslerp_pkg::THRESH_BITS-1:0]   csr_write_data
);
   localparam int CB = COMPONENT_BITS;
   localparam int PW = 2 * CB;
   localparam int SH_L = (PW < 32) ? 32 - PW : 0;
   localparam int SH_R = (PW >= 32) ? PW - 32 : 0;
   localparam int EW = PW + SH_L;
   localparam int DW = qslerp_pkg::DOT_BITS;
   localparam int MW = qslerp_pkg::MAG_BITS;
   localparam int RW = qslerp_pkg::RAD_BITS;
   localparam int FW = qslerp_pkg::FAC_BITS;
   localparam int XW = qslerp_pkg::XY_BITS;
   localparam int AW = qslerp_pkg::ANG_BITS;
   localparam int BW = qslerp_pkg::BLEND_BITS;
   localparam int FB = qslerp_pkg::FRAC_BITS;
   localparam int MPW = FW + CB;
   localparam int ACW = MPW + 2;
   localparam int SW = ACW - FB;
   localparam logic [BW-1:0] ONE_T = BW'(qslerp_pkg::ONE_Q16);
   localparam logic [2*MW-1:0] ONE_SQ = (2 * MW)'(1) << (2 * FB);
   localparam logic signed [ACW-1:0] HALF_LSB = ACW'(1) <<< (FB - 1);
   localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) <<< (CB - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   typedef struct packed {
      logic                     valid;
      qslerp_pkg::path_type     path;
      logic                     negate;
      logic [BW-1:0]            t;
      logic [3:0][CB-1:0]       a;
      logic [3:0][CB-1:0]       b;
      logic [MW-1:0]            absdot;
      logic [MW-1:0]            root;
   } side_type;

   logic [qslerp_pkg::THRESH_BITS-1:0] thr_ff;
   logic enable, out_load;

   side_type s1_side_in, s1_side_ff, s2_side_in, s2_side_ff, s3_side_ff, s4_side_ff;
   side_type sqrt_side, atan_side_in, atan_side, s5_side_ff, sin_side, div_side, s6_side_ff;
   logic signed [PW-1:0] prod_in [4];
   logic signed [PW-1:0] prod_ff [4];
   logic [2*MW-1:0] sq_ff;
   logic [RW-1:0] rad_in, rad_ff;
   logic [MW-1:0] root;
   logic signed [AW-1:0] theta;
   logic [15:0] t5, w5, t6, w6;
   logic signed [AW+16:0] p0, p1;
   logic signed [AW-1:0] ang_ff [2];
   logic signed [XW-1:0] sine [2];
   logic signed [FW-1:0] fac [2];
   logic signed [FW-1:0] fs0, fs1;
   logic signed [MPW-1:0] m0_in [4];
   logic signed [MPW-1:0] m1_in [4];
   logic signed [MPW-1:0] m0_ff [4];
   logic signed [MPW-1:0] m1_ff [4];
   logic signed [DW-1:0] dot;
   logic [DW-1:0] dot_abs;
   logic signed [CB-1:0] out_in [4];
   logic signed [CB-1:0] out_ff [4];
   qslerp_pkg::path_type path_ff;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= qslerp_pkg::THRESH_RESET;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   assign out_load = !rsp_valid_ff || rsp_ch.ready;
   assign enable = out_load || !s6_side_ff.valid;
   assign req_ch.ready = enable;

   // entry: capture request and form the four products
   always_comb begin
      s1_side_in = '0;
      s1_side_in.valid = req_ch.valid;
      s1_side_in.t = req_ch.blend_factor;
      s1_side_in.a[0] = req_ch.first_w;
      s1_side_in.a[1] = req_ch.first_x;
      s1_side_in.a[2] = req_ch.first_y;
      s1_side_in.a[3] = req_ch.first_z;
      s1_side_in.b[0] = req_ch.second_w;
      s1_side_in.b[1] = req_ch.second_x;
      s1_side_in.b[2] = req_ch.second_y;
      s1_side_in.b[3] = req_ch.second_z;
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = $signed(s1_side_in.a[k]) * $signed(s1_side_in.b[k]);
      end
   end

   // dot product and path decision
   always_comb begin
      logic signed [EW-1:0] ext;
      dot = '0;
      for (int k = 0; k < 4; k++) begin
         ext = (EW'(prod_ff[k]) <<< SH_L) >>> SH_R;
         dot = dot + DW'(ext);
      end
      dot_abs = dot[DW-1] ? DW'(-dot) : DW'(dot);
      s2_side_in = s1_side_ff;
      s2_side_in.negate = dot[DW-1];
      s2_side_in.absdot = dot_abs[MW-1:0];
      if (s1_side_ff.t[BW-1] || (s1_side_ff.t == '0)) begin
         s2_side_in.path = qslerp_pkg::PATH_LOW;
      end else if (s1_side_ff.t >= ONE_T) begin
         s2_side_in.path = qslerp_pkg::PATH_HIGH;
      end else if (dot_abs > DW'(thr_ff)) begin
         s2_side_in.path = qslerp_pkg::PATH_PARALLEL;
      end else begin
         s2_side_in.path = qslerp_pkg::PATH_BLEND;
      end
   end

   assign rad_in = (sq_ff > ONE_SQ) ? '0 : RW'(ONE_SQ - sq_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         sq_ff <= s2_side_ff.absdot * s2_side_ff.absdot;
         rad_ff <= rad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
         s2_side_ff <= '0;
         s3_side_ff <= '0;
         s4_side_ff <= '0;
      end else if (enable) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s2_side_in;
         s3_side_ff <= s2_side_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   qslerp_isqrt #(.SIDE_TYPE(side_type)) u_isqrt (
      .clock(clock), .reset(reset), .enable(enable),
      .rad(rad_ff), .enter_side(s4_side_ff),
      .root(root), .exit_side(sqrt_side)
   );

   always_comb begin
      atan_side_in = sqrt_side;
      atan_side_in.root = root;
   end

   qslerp_atan #(.STAGES(CORDIC_STAGES), .SIDE_TYPE(side_type)) u_atan (
      .clock(clock), .reset(reset), .enable(enable),
      .x_start(sqrt_side.absdot), .y_start(root), .enter_side(atan_side_in),
      .theta(theta), .exit_side(atan_side)
   );

   // scale the angle by t and by one minus t
   always_comb begin
      t5 = atan_side.t[15:0];
      w5 = 16'(17'(qslerp_pkg::ONE_Q16) - 17'(t5));
      p1 = $signed({1'b0, t5}) * theta;
      p0 = $signed({1'b0, w5}) * theta;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ang_ff[0] <= AW'(p0 >>> 16);
         ang_ff[1] <= AW'(p1 >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff <= '0;
      end else if (enable) begin
         s5_side_ff <= atan_side;
      end
   end

   qslerp_sin #(.STAGES(CORDIC_STAGES), .SIDE_TYPE(side_type)) u_sin (
      .clock(clock), .reset(reset), .enable(enable),
      .angle(ang_ff), .enter_side(s5_side_ff),
      .sine(sine), .exit_side(sin_side)
   );

   qslerp_div #(.SIDE_TYPE(side_type)) u_div (
      .clock(clock), .reset(reset), .enable(enable),
      .num(sine), .den(sin_side.root), .enter_side(sin_side),
      .quot(fac), .exit_side(div_side)
   );

   // weights times components; zero sine falls back to linear weights
   always_comb begin
      t6 = div_side.t[15:0];
      w6 = 16'(17'(qslerp_pkg::ONE_Q16) - 17'(t6));
      if (div_side.root == '0) begin
         fs0 = $signed(FW'({w6, 14'b0}));
         fs1 = $signed(FW'({t6, 14'b0}));
      end else begin
         fs0 = fac[0];
         fs1 = fac[1];
      end
      for (int k = 0; k < 4; k++) begin
         m0_in[k] = fs0 * $signed(div_side.a[k]);
         m1_in[k] = fs1 * $signed(div_side.b[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m0_ff <= m0_in;
         m1_ff <= m1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_side_ff <= '0;
      end else if (enable) begin
         s6_side_ff <= div_side;
      end
   end

   // sum, round, saturate and select by path
   always_comb begin
      logic signed [ACW-1:0] acc;
      logic signed [ACW-1:0] m1x;
      logic signed [SW-1:0] sh;
      logic signed [CB-1:0] blended;
      for (int k = 0; k < 4; k++) begin
         m1x = ACW'(m1_ff[k]);
         acc = ACW'(m0_ff[k]) + (s6_side_ff.negate ? -m1x : m1x) + HALF_LSB;
         sh = SW'(acc >>> FB);
         if (sh > SAT_HI) begin
            blended = CB'(SAT_HI);
         end else if (sh < SAT_LO) begin
            blended = CB'(SAT_LO);
         end else begin
            blended = CB'(sh);
         end
         case (s6_side_ff.path) inside
            qslerp_pkg::PATH_HIGH: out_in[k] = $signed(s6_side_ff.b[k]);
            qslerp_pkg::PATH_LOW, qslerp_pkg::PATH_PARALLEL:
               out_in[k] = $signed(s6_side_ff.a[k]);
            default: out_in[k] = blended;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
         path_ff <= s6_side_ff.path;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s6_side_ff.valid;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_w = out_ff[0];
   assign rsp_ch.out_x = out_ff[1];
   assign rsp_ch.out_y = out_ff[2];
   assign rsp_ch.out_z = out_ff[3];
   assign rsp_ch.path_code = path_ff;

`ifndef SYNTHESIS
   a_stall_blocks_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready && s6_side_ff.valid |-> !req_ch.ready)
      else $error("request taken while full pipeline is stalled");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      s6_side_ff.valid && out_load |=> rsp_valid_ff)
      else $error("finished request lost before the output register");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid_ff)
      else $error("response valid straight after reset");
`endif
endmodule

>>> sim/qslerp_checker.sv
`timescale 1ns / 1ps
// Checker for the quaternion slerp pipeline: predicts each response and compares it.
module qslerp_checker (
   input  logic                               clock,
   input  logic                               reset,
   qslerp_req_if                              req_ch,
   qslerp_rsp_if                              rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [qslerp_pkg::THRESH_BITS-1:0] csr_write_data,
   output int                                 mismatch_count,
   output int                                 pending_count
);

   typedef struct packed {
      logic signed [15:0]   w;
      logic signed [15:0]   x;
      logic signed [15:0]   y;
      logic signed [15:0]   z;
      qslerp_pkg::path_type path;
   } slerp_result_type;

   slerp_result_type  expected_results[$];
   logic [qslerp_pkg::THRESH_BITS-1:0] threshold;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_root(longint r);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > r) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (r >= res + bitv) begin
            r = r - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic longint arc_table(int i);
      longint t[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 17) ? t[i] : 0;
   endfunction

   function automatic longint arc_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < qslerp_pkg::CORDIC_STAGES_DEF; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += arc_table(i);
         end else begin
            x -= dx; y += dy; z -= arc_table(i);
         end
      end
      return z;
   endfunction

   function automatic longint rotated_sine(longint z);
      longint x, y, dx, dy;
      x = 652032874;
      y = 0;
      for (int i = 0; i < qslerp_pkg::CORDIC_STAGES_DEF; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arc_table(i);
         end else begin
            x += dx; y -= dy; z += arc_table(i);
         end
      end
      return y;
   endfunction

   function automatic longint weight_ratio(longint num, longint den);
      longint q, lim;
      q = (num * (64'sd1 <<< 30)) / den;
      lim = 64'sd2147483647;
      return q > lim ? lim : (q < -lim ? -lim : q);
   endfunction

   function automatic slerp_result_type predict_slerp(longint a[4], longint b[4], longint t);
      slerp_result_type r;
      longint dot, rad, s, theta, f0, f1, acc, sgn, v;
      longint outv[4];
      dot = 0;
      sgn = 1;
      r.path = qslerp_pkg::PATH_BLEND;
      if (t <= 0) begin
         r.path = qslerp_pkg::PATH_LOW;
         outv = a;
      end else if (t >= qslerp_pkg::ONE_Q16) begin
         r.path = qslerp_pkg::PATH_HIGH;
         outv = b;
      end else begin
         for (int k = 0; k < 4; k++) dot += a[k] * b[k];
         if ((dot < 0 ? -dot : dot) > longint'(threshold)) begin
            r.path = qslerp_pkg::PATH_PARALLEL;
            outv = a;
         end else begin
            if (dot < 0) begin
               dot = -dot;
               sgn = -1;
            end
            rad = (64'sd1 <<< 60) - dot * dot;
            if (rad < 0) rad = 0;
            s = int_root(rad);
            if (s == 0) begin
               f1 = t * 16384;
               f0 = (qslerp_pkg::ONE_Q16 - t) * 16384;
            end else begin
               theta = arc_angle(s, dot);
               f1 = weight_ratio(rotated_sine(floor_shift(t * theta, 16)), s);
               f0 = weight_ratio(rotated_sine(floor_shift((qslerp_pkg::ONE_Q16 - t) * theta,
                                                          16)), s);
            end
            for (int k = 0; k < 4; k++) begin
               acc = f0 * a[k] + sgn * f1 * b[k];
               v = floor_shift(acc + (64'sd1 <<< 29), 30);
               outv[k] = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
            end
         end
      end
      r.w = 16'(outv[0]); r.x = 16'(outv[1]); r.y = 16'(outv[2]); r.z = 16'(outv[3]);
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      longint a[4], b[4];
      slerp_result_type got, want;
      if (reset) begin
         threshold <= qslerp_pkg::THRESH_RESET;
         mismatch_count <= 0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) threshold <= csr_write_data;
         if (req_ch.valid && req_ch.ready) begin
            a = '{req_ch.first_w, req_ch.first_x, req_ch.first_y, req_ch.first_z};
            b = '{req_ch.second_w, req_ch.second_x, req_ch.second_y, req_ch.second_z};
            expected_results.push_back(predict_slerp(a, b, req_ch.blend_factor));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_w, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                    rsp_ch.path_code};
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10) $display("unexpected response %p", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %p actual %p", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> sim/tb_quaternion_slerp.sv
`timescale 1ns / 1ps
// Testbench top for the quaternion slerp pipeline: stimulus, threshold phases and verdict.
module tb_quaternion_slerp;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [qslerp_pkg::THRESH_BITS-1:0] csr_write_data = '0;
   int   mismatch_count, pending_count;
   int   send_idle_pct = 6, recv_idle_pct = 46;
   int   quiet_cycles = 0;

   qslerp_req_if req_ch ();
   qslerp_rsp_if rsp_ch ();

   quaternion_slerp dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   qslerp_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.first_w, req_ch.first_x, req_ch.first_y, req_ch.first_z} = '0;
      {req_ch.second_w, req_ch.second_x, req_ch.second_y, req_ch.second_z} = '0;
      req_ch.blend_factor = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(negedge clock) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high after acceptance; an idle drops it, the next request replaces the data
   task automatic send_request(logic [15:0] q1[4], logic [15:0] q2[4], logic [17:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.first_w, req_ch.first_x, req_ch.first_y, req_ch.first_z}
         <= {q1[0], q1[1], q1[2], q1[3]};
      {req_ch.second_w, req_ch.second_x, req_ch.second_y, req_ch.second_z}
         <= {q2[0], q2[1], q2[2], q2[3]};
      req_ch.blend_factor <= t;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (110) @(negedge clock);
   endtask

   task automatic write_threshold(logic [qslerp_pkg::THRESH_BITS-1:0] value);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random quaternion pair: mostly half-range components, with close and negated pairs
   task automatic random_pair(output logic [15:0] q1[4], output logic [15:0] q2[4]);
      int mode;
      mode = $urandom_range(9);
      for (int k = 0; k < 4; k++) begin
         q1[k] = (mode < 7) ? 16'($signed($urandom_range(32767)) - 16384) : 16'($urandom);
         if (mode < 3)
            q2[k] = q1[k] + 16'($signed($urandom_range(64)) - 32);
         else if (mode == 3)
            q2[k] = -q1[k];
         else
            q2[k] = (mode < 7) ? 16'($signed($urandom_range(32767)) - 16384) : 16'($urandom);
      end
   endtask

   function automatic logic [17:0] random_blend();
      int m;
      m = $urandom_range(9);
      if (m == 0) return 18'($urandom);
      if (m == 1) return 18'(qslerp_pkg::ONE_Q16);
      if (m == 2) return 18'd0;
      return 18'($urandom_range(65535, 1));
   endfunction

   initial begin
      logic [15:0] q1[4], q2[4];
      logic [qslerp_pkg::THRESH_BITS-1:0] settings[4];
      settings = '{qslerp_pkg::THRESH_RESET, 31'd0, 31'd1073741824, 31'd536870912};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      q1 = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
      q2 = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001};
      send_request(q1, q2, 18'h20000);
      send_request(q1, q2, 18'h00000);
      send_request(q1, q2, 18'h1ffff);
      send_request(q1, q2, 18'd65536);
      send_request(q1, q2, 18'd65535);
      send_request(q1, q2, 18'd1);
      send_request(q1, q2, 18'd32768);
      q1 = '{16'h7fff, 16'h0, 16'h0, 16'h0};
      send_request(q1, q1, 18'd32768);
      q2 = '{16'h8001, 16'h0, 16'h0, 16'h0};
      send_request(q1, q2, 18'd32768);
      q2 = '{16'h0, 16'h7fff, 16'h0, 16'h0};
      send_request(q1, q2, 18'd16384);
      q1 = '{16'h4000, 16'h4000, 16'h4000, 16'h4000};
      send_request(q1, q1, 18'd100);
      q1 = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
      send_request(q1, q1, 18'd40000);

      for (int phase = 0; phase < 6; phase++) begin
         drain_pipeline();
         write_threshold(settings[phase % 4]);
         if (phase == 2) begin
            send_idle_pct = 46;
            recv_idle_pct = 6;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 280; n++) begin
            random_pair(q1, q2);
            send_request(q1, q2, random_blend());
            if (n == 140) begin
               req_ch.valid <= 1'b0;
               while (pending_count != 0) @(negedge clock);
            end
         end
      end
      drain_pipeline();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
